// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the lidar packet parser; lpp_decode includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that an expression holds at every rising clock edge outside reset.
`define LPP_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lidar parser assertion failed");

// Checks that a consequent holds in the cycle after an antecedent.
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lidar parser assertion failed");

`else

`define LPP_ASSERT(label, clk, rst_n, expr)
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lpp_pkg.sv =====
// Types, constants and helper functions of the lidar packet parser.
package lpp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned AngleW    = 9;
  localparam int unsigned RpmW      = 13;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [ByteW-1:0]  StartByte  = 8'hFA;
  localparam logic [ByteW-1:0]  IndexLow   = 8'hA0;
  localparam logic [ByteW-1:0]  IndexHigh  = 8'hDB;
  localparam logic [WordW-1:0]  NearReset  = 16'd200;
  localparam logic [WordW-1:0]  ClampReset = 16'd3500;
  localparam logic [AngleW-1:0] TopAngle   = 9'd359;

  localparam logic [PosW-1:0] PosHunt      = 6'd0;
  localparam logic [PosW-1:0] PosIndex     = 6'd1;
  localparam logic [PosW-1:0] PosSpeedLo   = 6'd2;
  localparam logic [PosW-1:0] PosSpeedHi   = 6'd3;
  localparam logic [PosW-1:0] PosFirstRead = 6'd4;
  localparam logic [PosW-1:0] PosReadEnd   = 6'd39;
  localparam logic [PosW-1:0] PosLast      = 6'd41;

  localparam logic [2:0] OffDistHi   = 3'd3;
  localparam logic [2:0] OffLast     = 3'd5;
  localparam logic [2:0] ReadingLast = 3'd5;

  // Reciprocal of ten in 19 fractional bits; exact for every 16-bit dividend.
  localparam logic [WordW-1:0] RecipTen   = 16'hCCCD;
  localparam int unsigned      RecipShift = 19;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SAT_ENABLE  = 2'd0,
    CFG_NEAR_LIMIT  = 2'd1,
    CFG_CLAMP_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             sat_enable;
    logic [WordW-1:0] near_limit;
    logic [WordW-1:0] clamp_limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  function automatic logic [RpmW-1:0] div_by_ten(input logic [WordW-1:0] x);
    logic [2*WordW-1:0] prod;
    prod = x * RecipTen;
    return prod[RecipShift +: RpmW];
  endfunction

  // Base angle of a packet: 359 minus six degrees for each index step.
  function automatic logic [AngleW-1:0] base_angle_of(input logic [ByteW-1:0] idx);
    logic [ByteW-1:0]   diff;
    logic [AngleW-1:0]  step;
    diff = idx - IndexLow;
    step = {1'b0, diff[5:0], 2'b00} + {2'b00, diff[5:0], 1'b0};
    return TopAngle - step;
  endfunction

endpackage

// ===== hw/rtl/lpp_cfg_regs.sv =====
// Configuration registers of the lidar packet parser.
module lpp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [lpp_pkg::WordW-1:0]     cfg_wdata,
  output lpp_pkg::cfg_t                 cfg
);
  import lpp_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sat_enable  <= 1'b1;
      cfg_r.near_limit  <= NearReset;
      cfg_r.clamp_limit <= ClampReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAT_ENABLE:  cfg_r.sat_enable  <= cfg_wdata[0];
        CFG_NEAR_LIMIT:  cfg_r.near_limit  <= cfg_wdata;
        CFG_CLAMP_LIMIT: cfg_r.clamp_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpp_in_reg.sv =====
// Input register stage that holds one received byte for the decoder.
module lpp_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lpp_pkg::ByteW-1:0] in_rx_byte,
  input  logic                      advance,
  output lpp_pkg::in_item_t         item
);
  import lpp_pkg::*;

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] byte_r, byte_nxt;
  logic             take;

  // The held byte blocks a new transfer only when the decoder cannot take it.
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (take) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

// ===== hw/rtl/lpp_decode.sv =====
// Packet framing, field decoding and the result register of the parser.
`include "assert_macros.svh"

module lpp_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpp_pkg::cfg_t              cfg,
  input  lpp_pkg::in_item_t          item,
  output logic                       advance,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lpp_pkg::AngleW-1:0] out_angle_deg,
  output logic [lpp_pkg::WordW-1:0]  out_distance,
  output logic [lpp_pkg::WordW-1:0]  out_intensity,
  output logic [lpp_pkg::RpmW-1:0]   out_rpm,
  output logic                       out_packet_last
);
  import lpp_pkg::*;

  logic [PosW-1:0]   pos_r, pos_nxt;
  logic              good_r, good_nxt;
  logic [AngleW-1:0] base_r, base_nxt;
  logic [ByteW-1:0]  speed_lo_r, speed_lo_nxt;
  logic [RpmW-1:0]   rpm_r, rpm_nxt;
  logic [23:0]       held_r, held_nxt;
  logic [2:0]        rnum_r, rnum_nxt;
  logic [2:0]        off_r, off_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [AngleW-1:0] angle_r, angle_nxt;
  logic [WordW-1:0]  dist_r, dist_nxt;
  logic [WordW-1:0]  inten_r, inten_nxt;
  logic [RpmW-1:0]   orpm_r, orpm_nxt;
  logic              last_r, last_nxt;

  logic              fire;
  logic [ByteW-1:0]  b;
  logic [WordW-1:0]  raw_dist;
  logic [WordW-1:0]  sat_dist;
  logic              result_fire;
  logic              rnum_last;

  assign advance = !out_valid_r || !out_stall;
  assign fire    = item.valid && advance;
  assign b       = item.rx_byte;

  assign result_fire = fire && out_valid_nxt;
  assign rnum_last   = (rnum_r == ReadingLast);

  assign raw_dist = {b, held_r[23:16]};
  assign sat_dist = (cfg.sat_enable && (raw_dist > cfg.near_limit)) ?
                    cfg.clamp_limit : raw_dist;

  always_comb begin
    pos_nxt       = pos_r;
    good_nxt      = good_r;
    base_nxt      = base_r;
    speed_lo_nxt  = speed_lo_r;
    rpm_nxt       = rpm_r;
    held_nxt      = held_r;
    rnum_nxt      = rnum_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && out_stall;
    angle_nxt     = angle_r;
    dist_nxt      = dist_r;
    inten_nxt     = inten_r;
    orpm_nxt      = orpm_r;
    last_nxt      = last_r;

    if (fire) begin
      if (pos_r == PosHunt) begin
        if (b == StartByte) begin
          pos_nxt = PosIndex;
        end
      end else begin
        if (pos_r == PosIndex) begin
          good_nxt = (b >= IndexLow) && (b <= IndexHigh);
          base_nxt = good_nxt ? base_angle_of(b) : '0;
          rnum_nxt = '0;
          held_nxt = '0;
        end else if (pos_r == PosSpeedLo) begin
          speed_lo_nxt = b;
        end else if (pos_r == PosSpeedHi) begin
          rpm_nxt = div_by_ten({b, speed_lo_r});
          off_nxt = '0;
        end else if (pos_r inside {[PosFirstRead:PosReadEnd]}) begin
          off_nxt = (off_r == OffLast) ? 3'd0 : off_r + 3'd1;
          case (off_r)
            3'd0: held_nxt[7:0]   = b;
            3'd1: held_nxt[15:8]  = b;
            3'd2: held_nxt[23:16] = b;
            OffDistHi: begin
              // A reading completes on its high distance byte.
              if (good_r) begin
                out_valid_nxt = 1'b1;
                angle_nxt     = base_r - {6'd0, rnum_r};
                dist_nxt      = (sat_dist > cfg.clamp_limit) ? cfg.clamp_limit : sat_dist;
                inten_nxt     = held_r[15:0];
                orpm_nxt      = rpm_r;
                last_nxt      = (rnum_r == ReadingLast);
              end
              rnum_nxt = rnum_r + 3'd1;
            end
            default: ;
          endcase
        end
        pos_nxt = (pos_r >= PosLast) ? PosHunt : pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= PosHunt;
      good_r      <= 1'b0;
      base_r      <= '0;
      speed_lo_r  <= '0;
      rpm_r       <= '0;
      held_r      <= '0;
      rnum_r      <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      good_r      <= good_nxt;
      base_r      <= base_nxt;
      speed_lo_r  <= speed_lo_nxt;
      rpm_r       <= rpm_nxt;
      held_r      <= held_nxt;
      rnum_r      <= rnum_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    dist_r  <= dist_nxt;
    inten_r <= inten_nxt;
    orpm_r  <= orpm_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_angle_deg   = angle_r;
  assign out_distance    = dist_r;
  assign out_intensity   = inten_r;
  assign out_rpm         = orpm_r;
  assign out_packet_last = last_r;

  `LPP_ASSERT(a_pos_range, clk, rst_n, pos_r <= PosLast)
  `LPP_ASSERT(a_off_range, clk, rst_n, off_r <= OffLast)
  `LPP_ASSERT_NEXT(a_hunt_step, clk, rst_n, fire && (pos_r == PosHunt), pos_r <= PosIndex)
  `LPP_ASSERT_NEXT(a_last_count, clk, rst_n, result_fire, out_packet_last == $past(rnum_last))

endmodule

// ===== hw/rtl/lidar_packet_parser_core.sv =====
// Top level of the lidar packet parser: byte framing and reading decode.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_rx_byte
//   out      output     out_valid/out_stall angle_deg, distance, intensity, rpm, packet_last
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One byte is taken per cycle unless out_stall holds the decoder; the high distance byte of a
// reading in a good-index packet passes the input register, then loads the result register.
// The rate is set by the input register and the result register, one byte each per cycle.
// Reset (rst_n low, synchronous) returns the block to hunting for the start byte
// and loads the limit registers with their default values.
// A stalled result holds the decoder; the input then stalls once its register is full.
module lidar_packet_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpp_pkg::ByteW-1:0]     in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpp_pkg::AngleW-1:0]    out_angle_deg,
  output logic [lpp_pkg::WordW-1:0]     out_distance,
  output logic [lpp_pkg::WordW-1:0]     out_intensity,
  output logic [lpp_pkg::RpmW-1:0]      out_rpm,
  output logic                          out_packet_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [lpp_pkg::WordW-1:0]     cfg_wdata
);
  import lpp_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  logic     advance;

  lpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item       (item)
  );

  lpp_decode u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .item            (item),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_deg   (out_angle_deg),
    .out_distance    (out_distance),
    .out_intensity   (out_intensity),
    .out_rpm         (out_rpm),
    .out_packet_last (out_packet_last)
  );

endmodule

// ===== tb/lpp_reading_checker.sv =====
// Checker for the lidar packet parser: decodes the accepted bytes and compares each reading.
module lpp_reading_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lpp_pkg::ByteW-1:0]     in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lpp_pkg::AngleW-1:0]    out_angle_deg,
  input  logic [lpp_pkg::WordW-1:0]     out_distance,
  input  logic [lpp_pkg::WordW-1:0]     out_intensity,
  input  logic [lpp_pkg::RpmW-1:0]      out_rpm,
  input  logic                          out_packet_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lpp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [lpp_pkg::WordW-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import lpp_pkg::*;

  typedef struct {
    logic [AngleW-1:0] angle;
    logic [WordW-1:0]  distance;
    logic [WordW-1:0]  intensity;
    logic [RpmW-1:0]   rpm;
    logic              is_last;
  } reading_t;

  reading_t readings_due[$];

  // Limit registers as the parser should hold them.
  logic             sat_on;
  logic [WordW-1:0] near_thr;
  logic [WordW-1:0] clamp_thr;

  // Framing state of the packet being decoded.
  logic [PosW-1:0]   byte_pos;
  logic              index_ok;
  logic [AngleW-1:0] angle_base;
  logic [ByteW-1:0]  speed_lo;
  logic [RpmW-1:0]   rpm_now;
  logic [23:0]       reading_bytes;
  logic [2:0]        reading_idx;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string msg);
    if (fail_count < 40) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic [PosW-1:0]  pos;
    logic [2:0]       off;
    logic [WordW-1:0] dist_v;
    reading_t         r;
    pos = byte_pos;
    if (pos == PosHunt) begin
      if (b == StartByte) begin
        byte_pos = PosIndex;
      end
    end else begin
      if (pos == PosIndex) begin
        index_ok = (b >= IndexLow) && (b <= IndexHigh);
        angle_base = index_ok ?
          AngleW'(int'(TopAngle) - 6 * (int'(b) - int'(IndexLow))) : '0;
        reading_idx = '0;
        reading_bytes = '0;
      end else if (pos == PosSpeedLo) begin
        speed_lo = b;
      end else if (pos == PosSpeedHi) begin
        rpm_now = RpmW'(int'({b, speed_lo}) / 10);
      end else if (pos >= PosFirstRead && pos <= PosReadEnd) begin
        off = 3'((pos - PosFirstRead) % 6);
        if (off < OffDistHi) begin
          reading_bytes[8*off +: 8] = b;
        end else if (off == OffDistHi) begin
          if (index_ok) begin
            // Saturation is applied before the clamp.
            dist_v = {b, reading_bytes[23:16]};
            if (sat_on && dist_v > near_thr) dist_v = clamp_thr;
            if (dist_v > clamp_thr) dist_v = clamp_thr;
            r.angle = angle_base - AngleW'(reading_idx);
            r.distance = dist_v;
            r.intensity = reading_bytes[15:0];
            r.rpm = rpm_now;
            r.is_last = (reading_idx == ReadingLast);
            readings_due = {readings_due, r};
          end
          reading_idx = reading_idx + 3'd1;
        end
      end
      byte_pos = (pos >= PosLast) ? PosHunt : pos + PosW'(1);
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      report($sformatf("reading at angle %0d with none due", out_angle_deg));
    end else begin
      want = readings_due.pop_front();
      checked++;
      if (out_angle_deg !== want.angle)
        report($sformatf("angle_deg got %0d want %0d", out_angle_deg, want.angle));
      if (out_distance !== want.distance)
        report($sformatf("distance got %0d want %0d (angle %0d)", out_distance,
                         want.distance, want.angle));
      if (out_intensity !== want.intensity)
        report($sformatf("intensity got %0d want %0d (angle %0d)", out_intensity,
                         want.intensity, want.angle));
      if (out_rpm !== want.rpm)
        report($sformatf("rpm got %0d want %0d (angle %0d)", out_rpm, want.rpm, want.angle));
      if (out_packet_last !== want.is_last)
        report($sformatf("packet_last got %0b want %0b (angle %0d)", out_packet_last,
                         want.is_last, want.angle));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sat_on = 1'b1;
      near_thr = NearReset;
      clamp_thr = ClampReset;
      byte_pos = PosHunt;
      index_ok = 1'b0;
      angle_base = '0;
      speed_lo = '0;
      rpm_now = '0;
      reading_bytes = '0;
      reading_idx = '0;
      readings_due.delete();
    end else begin
      // A result can never stem from a byte taken at the same edge.
      if (out_valid === 1'b1 && out_stall === 1'b0) check_reading();
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SAT_ENABLE:  sat_on = cfg_wdata[0];
          CFG_NEAR_LIMIT:  near_thr = cfg_wdata;
          CFG_CLAMP_LIMIT: clamp_thr = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) decode_byte(in_rx_byte);
    end
    pending = readings_due.size();
  end

endmodule

// ===== tb/tb_lidar_packet_parser_core.sv =====
// Testbench top for the lidar packet parser: byte stimulus, limit settings and verdict.
module tb_lidar_packet_parser_core;
  import lpp_pkg::*;

  localparam int TimeoutCycles = 300000;
  localparam int PhaseBytes    = 84;
  localparam int FrameLen      = 42;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic [ByteW-1:0]     in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [AngleW-1:0]    out_angle_deg;
  logic [WordW-1:0]     out_distance;
  logic [WordW-1:0]     out_intensity;
  logic [RpmW-1:0]      out_rpm;
  logic                 out_packet_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [WordW-1:0]     cfg_wdata;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping.
  logic             calm;
  logic [WordW-1:0] near_cur;
  logic [WordW-1:0] clamp_cur;
  logic [ByteW-1:0] frame[FrameLen];
  int               sent_bytes;
  int               good_frames;
  int               bad_frames;
  int               settings_used;

  lidar_packet_parser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_deg   (out_angle_deg),
    .out_distance    (out_distance),
    .out_intensity   (out_intensity),
    .out_rpm         (out_rpm),
    .out_packet_last (out_packet_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  lpp_reading_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_deg   (out_angle_deg),
    .out_distance    (out_distance),
    .out_intensity   (out_intensity),
    .out_rpm         (out_rpm),
    .out_packet_last (out_packet_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("lidar_packet_parser_core verification failed");
    $finish;
  end

  // Result side: stall for a random number of cycles before each transfer.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  // Holds the input back until every predicted reading has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limits(input logic sat, input logic [WordW-1:0] near,
                            input logic [WordW-1:0] clamp);
    drain();
    // Let the last bytes of a frame that produced nothing leave the pipeline.
    repeat (4) @(negedge clk);
    write_reg(CFG_SAT_ENABLE, {15'b0, sat});
    write_reg(CFG_NEAR_LIMIT, near);
    write_reg(CFG_CLAMP_LIMIT, clamp);
    cfg_valid <= 1'b0;
    near_cur = near;
    clamp_cur = clamp;
    settings_used++;
  endtask

  function automatic logic [WordW-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return near_cur + WordW'($urandom_range(0, 2)) - 16'd1;
      3: return clamp_cur + WordW'($urandom_range(0, 2)) - 16'd1;
      4, 5, 6: return WordW'($urandom_range(0, 4000));
      default: return WordW'($urandom);
    endcase
  endfunction

  task automatic set_reading(input int k, input logic [WordW-1:0] inten,
                             input logic [WordW-1:0] dist_v);
    frame[4 + 6*k]     = inten[7:0];
    frame[4 + 6*k + 1] = inten[15:8];
    frame[4 + 6*k + 2] = dist_v[7:0];
    frame[4 + 6*k + 3] = dist_v[15:8];
  endtask

  task automatic build_frame(input logic [ByteW-1:0] idx, input logic [WordW-1:0] speed);
    logic [WordW-1:0] inten;
    frame[0] = StartByte;
    frame[1] = idx;
    frame[2] = speed[7:0];
    frame[3] = speed[15:8];
    for (int k = 0; k < 6; k++) begin
      inten = ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : WordW'($urandom);
      set_reading(k, inten, pick_distance());
      frame[4 + 6*k + 4] = ByteW'($urandom);
      frame[4 + 6*k + 5] = ByteW'($urandom);
    end
    frame[40] = ByteW'($urandom);
    frame[41] = ByteW'($urandom);
    if (idx >= IndexLow && idx <= IndexHigh) good_frames++;
    else bad_frames++;
  endtask

  // Sends the frame; a hold position of zero or more pauses the sender there.
  task automatic send_frame(input int hold_at);
    for (int i = 0; i < FrameLen; i++) begin
      if (i == hold_at) drain();
      push_byte(frame[i]);
    end
  endtask

  initial begin
    int               phase_bytes;
    int               pick;
    int               hold_at;
    logic [ByteW-1:0] idx;
    logic [WordW-1:0] speed;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SAT_ENABLE;
    cfg_wdata = '0;
    calm = 1'b0;
    near_cur = NearReset;
    clamp_cur = ClampReset;
    sent_bytes = 0;
    good_frames = 0;
    bad_frames = 0;
    settings_used = 1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, under the reset limits. Noise while hunting comes first.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_byte(8'hAA);

    // Lowest index, top speed, boundary distances, start bytes inside the frame.
    build_frame(IndexLow, 16'hFFFF);
    set_reading(0, 16'h0000, 16'h0000);
    set_reading(1, 16'hFFFF, 16'hFFFF);
    set_reading(2, 16'h00FF, NearReset);
    set_reading(3, 16'hFF00, NearReset + 16'd1);
    set_reading(4, 16'h5AA5, ClampReset);
    set_reading(5, 16'hA55A, ClampReset + 16'd1);
    frame[8] = StartByte;
    frame[40] = StartByte;
    frame[41] = StartByte;
    send_frame(-1);

    // Highest index and zero speed.
    build_frame(IndexHigh, 16'h0000);
    send_frame(-1);

    // Indexes just outside the range, and the start byte as an index.
    build_frame(IndexLow - 8'd1, 16'h1234);
    frame[10] = StartByte;
    send_frame(-1);
    build_frame(IndexHigh + 8'd1, 16'h4321);
    send_frame(-1);
    build_frame(StartByte, 16'h0A0A);
    send_frame(-1);

    // A good frame right after a bad one.
    build_frame(8'($urandom_range(IndexLow, IndexHigh)), WordW'($urandom));
    send_frame(-1);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: set_limits(1'b0, 16'h0000, 16'hFFFF);
        2: set_limits(1'b1, 16'h0000, 16'h0000);
        3: set_limits(1'b1, 16'hFFFF, 16'hFFFF);
        4: set_limits(1'b0, WordW'($urandom), WordW'($urandom_range(0, 3000)));
        5: set_limits(1'b1, 16'd5000, 16'd300);
        6: set_limits(1'($urandom), WordW'($urandom_range(0, 4000)), WordW'($urandom));
        default: ;
      endcase
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        // The sender waits for all readings at least once per run.
        hold_at = ($urandom_range(0, 9) == 0 || (ph == 1 && phase_bytes == 0)) ?
                  $urandom_range(1, FrameLen - 1) : -1;
        speed = ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : WordW'($urandom);
        if (pick < 12) begin
          repeat ($urandom_range(1, 6)) push_byte(ByteW'($urandom));
        end else begin
          if (pick < 22) begin
            idx = ($urandom_range(0, 1) == 0) ?
                  ByteW'($urandom_range(0, int'(IndexLow) - 1)) :
                  ByteW'($urandom_range(int'(IndexHigh) + 1, 255));
          end else begin
            idx = ByteW'($urandom_range(IndexLow, IndexHigh));
          end
          build_frame(idx, speed);
          send_frame(hold_at);
          phase_bytes += FrameLen;
        end
      end
    end

    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes: %0d good-index frames, %0d bad-index frames, %0d limit settings.",
             sent_bytes, good_frames, bad_frames, settings_used);
    $display("Compared %0d decoded readings field by field; %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("lidar_packet_parser_core verification clean");
    end else begin
      $display("lidar_packet_parser_core verification failed");
    end
    $finish;
  end

endmodule

// ===== lidar_packet_parser_core.f =====
+incdir+hw/rtl
hw/rtl/lpp_pkg.sv
hw/rtl/lpp_cfg_regs.sv
hw/rtl/lpp_in_reg.sv
hw/rtl/lpp_decode.sv
hw/rtl/lidar_packet_parser_core.sv
tb/lpp_reading_checker.sv
tb/tb_lidar_packet_parser_core.sv
